// ===== rtl/core/rmd_pkg.sv =====
// Shared types, constants and helper functions of the ROLZ match decoder.
package rmd_pkg;

   localparam int unsigned DEF_BLOCK_BITS = 16;
   localparam int unsigned SYM_W          = 9;
   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned HASH_W         = 16;
   localparam int unsigned BUCKETS        = 65536;
   localparam int unsigned SLOTS          = 15;
   localparam int unsigned SLOT_W         = 4;
   localparam int unsigned SLOT_AW        = 20;
   localparam int unsigned LEN_W          = 5;
   localparam int unsigned EPOCH_W        = 8;
   localparam int unsigned HASH_MULT      = 13131;
   localparam int unsigned MIN_MATCH      = 2;

   // Reciprocal of the slot count: code * 137 >> 11 equals code / 15 for all 8-bit codes.
   localparam int unsigned RECIP          = 137;
   localparam int unsigned RECIP_SHIFT    = 11;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             end_of_block;
   } rmd_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
      logic              error;
   } rmd_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_SLOT,
      ST_EMIT,
      ST_NEXT,
      ST_ERR
   } rmd_state_type;

   // One bucket header: the block generation it belongs to, how many slots
   // hold positions, and the ring index of the newest slot.
   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [SLOT_W-1:0]  fill;
      logic [SLOT_W-1:0]  head;
   } rmd_head_entry_type;

   typedef struct packed {
      logic head_rd;
      logic slot_rd;
      logic push;
      logic block_end;
   } rmd_bkt_ctl_type;

   typedef struct packed {
      logic rd_first;
      logic rd_next;
      logic wr;
   } rmd_hist_ctl_type;

   function automatic logic [LEN_W-1:0] match_quot(input logic [BYTE_W-1:0] code);
      logic [15:0] prod;
      begin
         prod = 16'(code) * 16'(RECIP);
         return LEN_W'(prod >> RECIP_SHIFT);
      end
   endfunction

   function automatic logic [SLOT_W-1:0] match_slot(input logic [BYTE_W-1:0] code);
      logic [BYTE_W-1:0] quot;
      logic [BYTE_W-1:0] rem;
      begin
         quot = BYTE_W'(match_quot(code));
         rem  = code - BYTE_W'(quot * BYTE_W'(SLOTS));
         return SLOT_W'(rem);
      end
   endfunction

endpackage

// ===== rtl/core/rmd_bucket_table.sv =====
// Bucket header and slot memories with block generation marks and clearing pass.
module rmd_bucket_table #(
   parameter int unsigned BLOCK_BITS = rmd_pkg::DEF_BLOCK_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rmd_pkg::rmd_bkt_ctl_type      bkt_ctl,
   input  logic [rmd_pkg::HASH_W-1:0]    bucket,
   input  logic [rmd_pkg::SLOT_W-1:0]    slot_n,
   input  logic [BLOCK_BITS-1:0]         push_pos,
   output logic [BLOCK_BITS-1:0]         src_pos,
   output logic                          clearing
);

   localparam int unsigned SlotDepth = rmd_pkg::BUCKETS * rmd_pkg::SLOTS;

   rmd_pkg::rmd_head_entry_type head_mem [rmd_pkg::BUCKETS];
   logic [BLOCK_BITS-1:0]       slot_mem [SlotDepth];

   rmd_pkg::rmd_head_entry_type head_q_ff;
   logic [BLOCK_BITS-1:0]       slot_q_ff;
   logic                        slot_hit_ff, slot_hit_in;
   logic [rmd_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic                        clearing_ff, clearing_in;
   logic [rmd_pkg::HASH_W-1:0]  clr_cnt_ff, clr_cnt_in;

   logic                        entry_live;
   logic [rmd_pkg::SLOT_W-1:0]  cur_head, cur_fill, rd_idx, new_head, new_fill;
   logic [rmd_pkg::SLOT_W:0]    slot_sum;
   logic [rmd_pkg::SLOT_AW-1:0] base_addr, rd_addr, wr_addr;
   rmd_pkg::rmd_head_entry_type new_entry;

   // A header written under an older block generation reads as an empty bucket.
   always_comb begin
      entry_live = (head_q_ff.epoch == epoch_ff);
      cur_head   = entry_live ? head_q_ff.head : '0;
      cur_fill   = entry_live ? head_q_ff.fill : '0;
      slot_sum   = (rmd_pkg::SLOT_W+1)'(cur_head) + (rmd_pkg::SLOT_W+1)'(slot_n);
      rd_idx     = (slot_sum >= (rmd_pkg::SLOT_W+1)'(rmd_pkg::SLOTS))
                   ? rmd_pkg::SLOT_W'(slot_sum - (rmd_pkg::SLOT_W+1)'(rmd_pkg::SLOTS))
                   : rmd_pkg::SLOT_W'(slot_sum);
      slot_hit_in = entry_live && (slot_n < cur_fill);
      new_head   = (cur_head == '0) ? rmd_pkg::SLOT_W'(rmd_pkg::SLOTS - 1)
                                    : cur_head - rmd_pkg::SLOT_W'(1);
      new_fill   = (cur_fill == rmd_pkg::SLOT_W'(rmd_pkg::SLOTS))
                   ? cur_fill : cur_fill + rmd_pkg::SLOT_W'(1);
      new_entry.epoch = epoch_ff;
      new_entry.fill  = new_fill;
      new_entry.head  = new_head;
      base_addr  = {bucket, 4'b0000} - rmd_pkg::SLOT_AW'(bucket);
      rd_addr    = base_addr + rmd_pkg::SLOT_AW'(rd_idx);
      wr_addr    = base_addr + rmd_pkg::SLOT_AW'(new_head);
   end

   // Block generations: each block end advances the mark; when it runs out
   // the headers are swept back to generation zero.
   always_comb begin
      epoch_in    = epoch_ff;
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + rmd_pkg::HASH_W'(1);
         if (clr_cnt_ff == '1) begin
            clearing_in = 1'b0;
         end
      end
      if (bkt_ctl.block_end) begin
         if (epoch_ff == '1) begin
            epoch_in    = rmd_pkg::EPOCH_W'(1);
            clearing_in = 1'b1;
            clr_cnt_in  = '0;
         end else begin
            epoch_in = epoch_ff + rmd_pkg::EPOCH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff    <= rmd_pkg::EPOCH_W'(1);
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         epoch_ff    <= epoch_in;
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_ctl.head_rd) begin
         head_q_ff <= head_mem[bucket];
      end
      if (clearing_ff) begin
         head_mem[clr_cnt_ff] <= '0;
      end else if (bkt_ctl.push) begin
         head_mem[bucket] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_ctl.slot_rd) begin
         slot_q_ff   <= slot_mem[rd_addr];
         slot_hit_ff <= slot_hit_in;
      end
      if (bkt_ctl.push) begin
         slot_mem[wr_addr] <= push_pos;
      end
   end

   assign src_pos  = slot_hit_ff ? slot_q_ff : '0;
   assign clearing = clearing_ff;

endmodule

// ===== rtl/core/rmd_history.sv =====
// Block history memory with its copy read pointer.
module rmd_history #(
   parameter int unsigned BLOCK_BITS = rmd_pkg::DEF_BLOCK_BITS
) (
   input  logic                          clock,
   input  rmd_pkg::rmd_hist_ctl_type     hist_ctl,
   input  logic [BLOCK_BITS-1:0]         src_pos,
   input  logic [BLOCK_BITS-1:0]         wr_addr,
   input  logic [rmd_pkg::BYTE_W-1:0]    wr_data,
   output logic [rmd_pkg::BYTE_W-1:0]    rd_data
);

   localparam int unsigned HistDepth = 1 << BLOCK_BITS;

   logic [rmd_pkg::BYTE_W-1:0] hist_mem [HistDepth];
   logic [rmd_pkg::BYTE_W-1:0] rd_data_ff;
   logic [BLOCK_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [BLOCK_BITS-1:0]      rd_addr;
   logic                       rd_en;

   always_comb begin
      rd_addr   = hist_ctl.rd_first ? src_pos : rd_ptr_ff;
      rd_en     = hist_ctl.rd_first || hist_ctl.rd_next;
      rd_ptr_in = rd_en ? rd_addr + BLOCK_BITS'(1) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
      if (hist_ctl.wr) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rolz_match_decoder_top.sv =====
// Top level of the ROLZ match decoder: symbol sequencer, context state and result register.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  rmd_req_type  (symbol, end_of_block)
//   rsp_      out        rsp_valid / rsp_stall  rmd_rsp_type  (out_byte, last_of_run, error)
//
// A literal or an error symbol goes from the header lookup to the emit or error
// state; a match goes through the header lookup and the slot read, and
// then alternates the emit and next states over its bytes, since each byte's
// context hash selects the header read for the next, and that read is registered.
// After reset, and again after every 255th end of block, a clearing pass
// sweeps the 65536 bucket headers, one per cycle, while req_stall is high.
// Reset is synchronous and active high; it clears the sequencer, context,
// position and result valid, and starts the clearing pass.
// A stalled result waits in the output register; the sequencer holds its
// next byte until the register frees, and a new transaction may be accepted
// while the last result of the previous one still waits.
module rolz_match_decoder_top #(
   parameter int unsigned BLOCK_BITS = rmd_pkg::DEF_BLOCK_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rmd_pkg::rmd_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rmd_pkg::rmd_rsp_type  rsp_data
);

   // One past the last block position: a symbol may fill history up to here.
   localparam logic [BLOCK_BITS+1:0] HistLimit = {2'b01, {BLOCK_BITS{1'b0}}};

   rmd_pkg::rmd_state_type        state_ff, state_in;
   logic [rmd_pkg::SYM_W-1:0]     sym_ff, sym_in;
   logic                          eob_ff, eob_in;
   logic [rmd_pkg::LEN_W-1:0]     left_ff, left_in;
   logic [rmd_pkg::HASH_W-1:0]    hash_ff, hash_in;
   logic [rmd_pkg::HASH_W-1:0]    prev_ff, prev_in;
   logic [BLOCK_BITS:0]           wp_ff, wp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rmd_pkg::rmd_rsp_type          rsp_data_ff, rsp_data_in;

   logic                          req_accept;
   logic                          out_free;
   logic                          clearing;
   logic                          is_match;
   logic [rmd_pkg::BYTE_W-1:0]    code;
   logic [rmd_pkg::LEN_W-1:0]     sym_len;
   logic [rmd_pkg::SLOT_W-1:0]    sym_slot;
   logic [BLOCK_BITS+1:0]         end_pos;
   logic                          sym_err;
   logic [rmd_pkg::BYTE_W-1:0]    cur_byte;
   logic [29:0]                   hash_prod;
   logic [BLOCK_BITS-1:0]         src_pos;
   logic [rmd_pkg::BYTE_W-1:0]    hist_rd_data;

   logic                          emit_fire;
   logic                          err_fire;
   logic                          run_done;
   rmd_pkg::rmd_bkt_ctl_type      bkt_ctl;
   rmd_pkg::rmd_hist_ctl_type     hist_ctl;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != rmd_pkg::ST_IDLE) || clearing;
   assign req_accept = req_valid && !req_stall;

   // Symbol decode. A match fails when no byte of the block exists yet, and any
   // symbol fails when its bytes would run past the end of the history.
   always_comb begin
      is_match = sym_ff[rmd_pkg::SYM_W-1];
      code     = sym_ff[rmd_pkg::BYTE_W-1:0];
      sym_slot = rmd_pkg::match_slot(code);
      sym_len  = is_match ? rmd_pkg::match_quot(code) + rmd_pkg::LEN_W'(rmd_pkg::MIN_MATCH)
                          : rmd_pkg::LEN_W'(1);
      end_pos  = (BLOCK_BITS+2)'(wp_ff) + (BLOCK_BITS+2)'(sym_len);
      sym_err  = (is_match && (wp_ff == '0)) || (end_pos > HistLimit);
      cur_byte = is_match ? hist_rd_data : code;
      hash_prod = 30'(prev_ff) * 30'(rmd_pkg::HASH_MULT);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmd_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = rmd_pkg::ST_HEAD;
            end
         end
         rmd_pkg::ST_HEAD: begin
            if (sym_err) begin
               state_in = rmd_pkg::ST_ERR;
            end else if (is_match) begin
               state_in = rmd_pkg::ST_SLOT;
            end else begin
               state_in = rmd_pkg::ST_EMIT;
            end
         end
         rmd_pkg::ST_SLOT: begin
            state_in = rmd_pkg::ST_EMIT;
         end
         rmd_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = (left_ff == rmd_pkg::LEN_W'(1)) ? rmd_pkg::ST_IDLE
                                                          : rmd_pkg::ST_NEXT;
            end
         end
         rmd_pkg::ST_NEXT: begin
            state_in = rmd_pkg::ST_EMIT;
         end
         rmd_pkg::ST_ERR: begin
            if (out_free) begin
               state_in = rmd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmd_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory and datapath controls for each state.
   always_comb begin
      emit_fire = 1'b0;
      err_fire  = 1'b0;
      bkt_ctl   = '0;
      hist_ctl  = '0;
      case (state_ff)
         rmd_pkg::ST_IDLE: begin
            bkt_ctl.head_rd = req_accept;
         end
         rmd_pkg::ST_HEAD: begin
            bkt_ctl.slot_rd = is_match && !sym_err;
         end
         rmd_pkg::ST_SLOT: begin
            hist_ctl.rd_first = 1'b1;
         end
         rmd_pkg::ST_EMIT: begin
            emit_fire    = out_free;
            bkt_ctl.push = out_free;
            hist_ctl.wr  = out_free;
         end
         rmd_pkg::ST_NEXT: begin
            bkt_ctl.head_rd  = 1'b1;
            hist_ctl.rd_next = 1'b1;
         end
         rmd_pkg::ST_ERR: begin
            err_fire = out_free;
         end
         default: begin
            emit_fire = 1'b0;
         end
      endcase
      run_done          = (emit_fire && (left_ff == rmd_pkg::LEN_W'(1))) || err_fire;
      bkt_ctl.block_end = run_done && eob_ff;
   end

   // Context, position and result register updates.
   always_comb begin
      sym_in       = req_accept ? req_data.symbol : sym_ff;
      eob_in       = req_accept ? req_data.end_of_block : eob_ff;
      left_in      = left_ff;
      hash_in      = hash_ff;
      prev_in      = prev_ff;
      wp_in        = wp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == rmd_pkg::ST_HEAD) begin
         left_in = sym_len;
      end
      if (emit_fire) begin
         left_in      = left_ff - rmd_pkg::LEN_W'(1);
         hash_in      = hash_prod[rmd_pkg::HASH_W-1:0] + rmd_pkg::HASH_W'(cur_byte);
         prev_in      = {prev_ff[rmd_pkg::BYTE_W-1:0], cur_byte};
         wp_in        = wp_ff + (BLOCK_BITS+1)'(1);
         rsp_valid_in = 1'b1;
         rsp_data_in.out_byte    = cur_byte;
         rsp_data_in.last_of_run = (left_ff == rmd_pkg::LEN_W'(1));
         rsp_data_in.error       = 1'b0;
      end
      if (err_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.out_byte    = '0;
         rsp_data_in.last_of_run = 1'b1;
         rsp_data_in.error       = 1'b1;
      end
      // The end of a block restarts context and position after its last result.
      if (bkt_ctl.block_end) begin
         hash_in = '0;
         prev_in = '0;
         wp_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmd_pkg::ST_IDLE;
         hash_ff      <= '0;
         prev_ff      <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         prev_ff      <= prev_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      eob_ff      <= eob_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

   rmd_bucket_table #(
      .BLOCK_BITS (BLOCK_BITS)
   ) u_bucket_table (
      .clock    (clock),
      .reset    (reset),
      .bkt_ctl  (bkt_ctl),
      .bucket   (hash_ff),
      .slot_n   (sym_slot),
      .push_pos (wp_ff[BLOCK_BITS-1:0]),
      .src_pos  (src_pos),
      .clearing (clearing)
   );

   rmd_history #(
      .BLOCK_BITS (BLOCK_BITS)
   ) u_history (
      .clock    (clock),
      .hist_ctl (hist_ctl),
      .src_pos  (src_pos),
      .wr_addr  (wp_ff[BLOCK_BITS-1:0]),
      .wr_data  (cur_byte),
      .rd_data  (hist_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted transaction always goes to the bucket header lookup next.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == rmd_pkg::ST_HEAD))
      else $error("accepted transaction did not start its header lookup");

   // The write position never runs past the end of the history.
   assert property (@(posedge clock) disable iff (reset)
      ((BLOCK_BITS+2)'(wp_ff) <= HistLimit))
      else $error("write position beyond history size");

   // A byte is only emitted while bytes of the current run remain.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmd_pkg::ST_EMIT) |-> (left_ff != '0))
      else $error("byte emit with empty run counter");

   // An error result is always the single, zero-valued result of its symbol.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error) |-> (rsp_data.last_of_run && (rsp_data.out_byte == '0)))
      else $error("malformed error result");

endmodule
